/* src/bpr_pkg.sv */
// Shared constants and types for the bitplane rotate block.
`timescale 1ns / 1ps

package bpr_pkg;

   // Source plane geometry
   localparam int MAX_SRC_ROWS      = 256;
   localparam int MAX_SRC_ROW_BYTES = 64;
   localparam int ROW_W  = $clog2(MAX_SRC_ROWS);
   localparam int COL_W  = $clog2(MAX_SRC_ROW_BYTES);
   localparam int ADDR_W = ROW_W + COL_W;

   // Field widths
   localparam int REQ_ROW_W  = 9;
   localparam int REQ_COL_W  = 6;
   localparam int BYTE_W     = 8;
   localparam int SRC_WIDTH_W  = 10;
   localparam int SRC_HEIGHT_W = 9;
   localparam int DST_BYTES_W  = 6;
   localparam int CSR_DATA_W   = 10;
   localparam int CSR_INDEX_W  = 2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_WIDTH     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_HEIGHT    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DST_ROW_BYTES = 2'd2;

   // Register reset values
   localparam logic [SRC_WIDTH_W-1:0]  SRC_WIDTH_RST     = 10'd512;
   localparam logic [SRC_HEIGHT_W-1:0] SRC_HEIGHT_RST    = 9'd256;
   localparam logic [DST_BYTES_W-1:0]  DST_ROW_BYTES_RST = 6'd32;

   // Request modes
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   // One access to the plane memory
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] wdata;
   } plane_req_type;

endpackage

/* src/bpr_plane.sv */
// Single-port source plane memory with registered read data.
`timescale 1ns / 1ps

module bpr_plane
   import bpr_pkg::*;
(
   input  logic              clock,
   input  plane_req_type     req,
   output logic [BYTE_W-1:0] rdata
);

   localparam int DEPTH = MAX_SRC_ROWS * MAX_SRC_ROW_BYTES;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.addr] <= req.wdata;
      end
      if (req.rd_en) begin
         rdata_ff <= mem[req.addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* src/bitplane_rotate_90_clockwise.sv */
// Top level: rotates a packed 1-bit bitplane 90 degrees clockwise on read.
`timescale 1ns / 1ps
// Write beat: stored at the accept edge, no busy, no result; one beat per cycle when idle.
// Read beat inside the destination: up to eight byte reads of the single-port plane
//   memory, busy high while the gather runs, result strobe in the cycle busy falls.
// Read beat outside the destination: result strobe in the cycle after accept, no busy.
// Results are strobed for one cycle; the receiver cannot stall.
// Synchronous active-high reset clears control and sets the size registers to their reset
//   values; plane contents are undefined until written.

module bitplane_rotate_90_clockwise
   import bpr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // command channel
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_mode,
   input  logic [REQ_ROW_W-1:0]    req_row,
   input  logic [REQ_COL_W-1:0]    req_byte_col,
   input  logic [BYTE_W-1:0]       req_data,
   // result channel
   output logic                    rsp_valid,
   output logic [BYTE_W-1:0]       rsp_out_byte,
   output logic                    rsp_outside,
   // configuration
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   localparam logic [3:0] LAST_STEP = 4'd8;

   // size registers
   logic [SRC_WIDTH_W-1:0]  src_width_ff;
   logic [SRC_HEIGHT_W-1:0] src_height_ff;
   logic [DST_BYTES_W-1:0]  dst_row_bytes_ff;

   // sequencer
   state_type            state_ff, state_in;
   logic [3:0]           step_ff, step_in;      // 0..7 issue, 1..8 capture
   logic                 use_ff, use_in;        // a read was issued last cycle
   logic [2:0]           pm_ff, pm_in;          // bit slot of that read
   logic [REQ_ROW_W-1:0] row_ff, row_in;
   logic [REQ_COL_W-1:0] col_ff, col_in;
   logic [BYTE_W-1:0]    acc_ff, acc_in;

   // result registers
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]    rsp_byte_ff, rsp_byte_in;
   logic                 rsp_outside_ff, rsp_outside_in;

   plane_req_type        plane_req;
   logic [BYTE_W-1:0]    plane_rdata;

   logic accept;
   logic rd_outside;

   // per-step gather address
   logic [REQ_COL_W-1:0]    src_bcol;       // source byte column = dest row / 8
   logic [2:0]              src_xbit;       // pixel within that byte
   logic [SRC_HEIGHT_W-1:0] dst_c;          // destination column of this bit
   logic [SRC_HEIGHT_W-1:0] src_y;
   logic                    step_inside;
   logic                    step_issue;
   logic                    got_bit;

   assign accept = start && !busy;
   assign rd_outside = ({1'b0, req_row} >= src_width_ff) ||
                       (req_byte_col >= dst_row_bytes_ff);

   assign src_bcol = row_ff[REQ_ROW_W-1:3];
   assign src_xbit = row_ff[2:0];
   assign dst_c    = {col_ff, step_ff[2:0]};
   assign src_y    = src_height_ff - SRC_HEIGHT_W'(1) - dst_c;

   // A slot reads memory only when the column lies in the source and the
   // source pixel lies in the stored plane; otherwise the bit stays zero.
   assign step_inside = (dst_c < src_height_ff) &&
                        (32'(src_y) < 32'(MAX_SRC_ROWS)) &&
                        (32'(src_bcol) < 32'(MAX_SRC_ROW_BYTES));
   assign step_issue  = (state_ff == ST_RUN) && !step_ff[3] && step_inside;

   // Pick the source pixel out of the returned byte, MSB leftmost.
   assign got_bit = plane_rdata[3'd7 - src_xbit];

   // Plane port: host writes while idle, gather reads while running.
   always_comb begin
      plane_req = '0;
      if (state_ff == ST_RUN) begin
         plane_req.rd_en = step_issue;
         plane_req.addr  = {src_y[ROW_W-1:0], src_bcol[COL_W-1:0]};
      end else begin
         plane_req.wr_en = accept && (req_mode == MODE_WRITE) &&
                           (32'(req_row) < 32'(MAX_SRC_ROWS)) &&
                           (32'(req_byte_col) < 32'(MAX_SRC_ROW_BYTES));
         plane_req.addr  = {req_row[ROW_W-1:0], req_byte_col[COL_W-1:0]};
         plane_req.wdata = req_data;
      end
   end

   bpr_plane u_plane (
      .clock (clock),
      .req   (plane_req),
      .rdata (plane_rdata)
   );

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      use_in         = 1'b0;
      pm_in          = pm_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      acc_in         = acc_ff;
      rsp_valid_in   = 1'b0;
      rsp_byte_in    = rsp_byte_ff;
      rsp_outside_in = rsp_outside_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_mode == MODE_READ)) begin
               if (rd_outside) begin
                  rsp_valid_in   = 1'b1;
                  rsp_byte_in    = '0;
                  rsp_outside_in = 1'b1;
               end else begin
                  state_in = ST_RUN;
                  step_in  = '0;
                  row_in   = req_row;
                  col_in   = req_byte_col;
                  acc_in   = '0;
               end
            end
         end
         ST_RUN: begin
            // capture the read issued last cycle
            if (use_ff && got_bit) begin
               acc_in[3'd7 - pm_ff] = 1'b1;
            end
            use_in  = step_issue;
            pm_in   = step_ff[2:0];
            step_in = step_ff + 4'd1;
            if (step_ff == LAST_STEP) begin
               state_in       = ST_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_outside_in = 1'b0;
               rsp_byte_in    = acc_in;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         use_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         use_ff       <= use_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pm_ff          <= pm_in;
      row_ff         <= row_in;
      col_ff         <= col_in;
      acc_ff         <= acc_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_outside_ff <= rsp_outside_in;
   end

   // size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff     <= SRC_WIDTH_RST;
         src_height_ff    <= SRC_HEIGHT_RST;
         dst_row_bytes_ff <= DST_ROW_BYTES_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SRC_WIDTH:     src_width_ff     <= csr_wdata[SRC_WIDTH_W-1:0];
            CSR_SRC_HEIGHT:    src_height_ff    <= csr_wdata[SRC_HEIGHT_W-1:0];
            CSR_DST_ROW_BYTES: dst_row_bytes_ff <= csr_wdata[DST_BYTES_W-1:0];
            default: ;
         endcase
      end
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_outside  = rsp_outside_ff;

   // The memory port never writes while the gather is reading.
   a_no_wr_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> !plane_req.wr_en)
      else $error("plane write during gather");

   // An outside beat always carries a zero byte.
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_outside) |-> (rsp_out_byte == '0))
      else $error("outside result with nonzero byte");

   // An inside read enters the gather on the next cycle.
   a_read_runs: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_mode == MODE_READ) && !rd_outside) |=> busy)
      else $error("inside read did not start the gather");

   // A gathered result is strobed just as the sequencer returns to idle.
   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RUN) && (step_ff == LAST_STEP)) |=> (rsp_valid && !busy))
      else $error("gather finished without a result strobe");

endmodule
